// ----- rtl/core/suws_pkg.sv -----
// ---------------------------------------------------------------------------
// suws_pkg: shared types and constants for the sorted word set
// Holds the payload structs, status codes, default sizes and a case-folding function.
// ---------------------------------------------------------------------------
package suws_pkg;

	localparam int unsigned DefCapacity = 128;
	localparam int unsigned DefMaxLen   = 32;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_PRESENT  = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	typedef struct packed {
		logic [7:0] char_code;
		logic       word_end;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [6:0] position;
		logic [7:0] word_total;
	} out_word_t;

	// Fold an upper-case ASCII letter to lower case.
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/suws_store.sv -----
// ---------------------------------------------------------------------------
// suws_store: word table memory
// One byte wide, one write port and one registered read port.
// ---------------------------------------------------------------------------
module suws_store import suws_pkg::*; #(
	parameter int unsigned AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [2**AW];

	// Synchronous write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/sorted_unique_word_set.sv -----
// ---------------------------------------------------------------------------
// sorted_unique_word_set: sorted table of distinct words
// Gathers words byte by byte, binary-searches a byte-wide table and
// inserts absent words in sorted position.
// ---------------------------------------------------------------------------
//  channel | direction | content
//  in      | input     | one byte of a word, with word-end mark
//  out     | output    | status, position and word total per word
//
//  A word end starts a binary search, unless the word is too long or the table
//  is full, of up to log2(CAPACITY)+1 probes; a probe picks the middle row and
//  compares up to MAX_LEN bytes through the single memory read port. An
//  insertion then moves (count-pos) rows of 2**ceil(log2(MAX_LEN)) bytes one
//  byte at a time and writes MAX_LEN bytes of the new row. The result is offered
//  in the cycle after the last write. Reset clears the count, gather, search
//  and result registers; the table needs no clearing.
//  The block holds in_ready low while a result waits on a stalled out channel.
// ---------------------------------------------------------------------------
module sorted_unique_word_set import suws_pkg::*; #(
	parameter int unsigned CAPACITY = DefCapacity,
	parameter int unsigned MAX_LEN  = DefMaxLen
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	localparam int unsigned RW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned LW = $clog2(MAX_LEN);
	localparam int unsigned NW = $clog2(MAX_LEN + 1);
	localparam int unsigned AW = RW + LW;
	localparam int unsigned RowPitch = 2**LW;

	typedef enum logic [6:0] {
		S_GATHER = 7'b0000001,
		S_PROBE  = 7'b0000010,
		S_CMP    = 7'b0000100,
		S_SHRD   = 7'b0001000,
		S_SHWR   = 7'b0010000,
		S_WRITE  = 7'b0100000,
		S_OUT    = 7'b1000000
	} state_t;

	state_t state_q;
	logic [7:0]    word_q [MAX_LEN];
	logic [NW-1:0] len_q;
	logic          ovf_q;
	logic [CW-1:0] count_q, lo_q, hi_q, mid_q;
	logic [LW-1:0] byte_q;
	logic          rd_wait_q;
	logic [AW-1:0] src_q;
	out_word_t     res_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;
	logic [7:0]    ch;
	logic          overflow_now;
	logic [CW:0]   mid_sum;

	assign ch = fold_case(in_data.char_code);
	assign overflow_now = ovf_q || (len_q == NW'(MAX_LEN));
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};

	suws_store #(.AW(AW)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// Memory port addressing per state.
	always_comb begin
		we    = 1'b0;
		waddr = src_q + AW'(RowPitch);
		wdata = rdata;
		raddr = {mid_q[RW-1:0], byte_q};
		if (state_q == S_SHRD) begin
			raddr = src_q;
		end
		if (state_q == S_SHWR && rd_wait_q) begin
			we = 1'b1;
		end
		if (state_q == S_WRITE) begin
			we    = 1'b1;
			waddr = {lo_q[RW-1:0], byte_q};
			wdata = word_q[byte_q];
		end
	end

	assign in_ready  = (state_q == S_GATHER);
	assign out_valid = (state_q == S_OUT);
	assign out_data  = res_q;

	// Sequencer: gather, search, shift, write and hand out the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_GATHER;
			len_q     <= '0;
			ovf_q     <= 1'b0;
			count_q   <= '0;
			rd_wait_q <= 1'b0;
			lo_q      <= '0;
			hi_q      <= '0;
			mid_q     <= '0;
			byte_q    <= '0;
			src_q     <= '0;
			res_q     <= '0;
		end else begin
			case (state_q)
				S_GATHER: begin
					if (in_valid) begin
						if (!overflow_now) begin
							len_q <= len_q + 1'b1;
						end
						ovf_q <= overflow_now;
						if (in_data.word_end) begin
							lo_q <= '0;
							hi_q <= count_q;
							res_q.position   <= '0;
							res_q.word_total <= 8'(count_q);
							if (overflow_now) begin
								res_q.status <= ST_TOO_LONG;
								state_q      <= S_OUT;
							end else if (count_q == CW'(CAPACITY)) begin
								res_q.status <= ST_FULL;
								state_q      <= S_OUT;
							end else begin
								state_q <= S_PROBE;
							end
						end
					end
				end
				S_PROBE: begin
					byte_q    <= '0;
					rd_wait_q <= 1'b0;
					if (lo_q < hi_q) begin
						mid_q   <= CW'(mid_sum >> 1);
						state_q <= S_CMP;
					end else begin
						// Absent: move rows lo..count-1 up one row, top byte first.
						src_q     <= AW'(count_q * RowPitch) - 1'b1;
						byte_q    <= '0;
						state_q   <= (count_q == lo_q) ? S_WRITE : S_SHRD;
					end
				end
				S_CMP: begin
					rd_wait_q <= ~rd_wait_q;
					if (rd_wait_q) begin
						if (rdata != word_q[byte_q]) begin
							if (rdata < word_q[byte_q]) begin
								lo_q <= mid_q + 1'b1;
							end else begin
								hi_q <= mid_q;
							end
							state_q <= S_PROBE;
						end else if (byte_q == LW'(MAX_LEN - 1)) begin
							res_q.status   <= ST_PRESENT;
							res_q.position <= 7'(mid_q);
							state_q        <= S_OUT;
						end else begin
							byte_q <= byte_q + 1'b1;
						end
					end
				end
				S_SHRD: begin
					rd_wait_q <= 1'b1;
					state_q   <= S_SHWR;
				end
				S_SHWR: begin
					rd_wait_q <= 1'b0;
					if (src_q == AW'(lo_q * RowPitch)) begin
						state_q <= S_WRITE;
					end else begin
						src_q   <= src_q - 1'b1;
						state_q <= S_SHRD;
					end
				end
				S_WRITE: begin
					if (byte_q == LW'(MAX_LEN - 1)) begin
						count_q          <= count_q + 1'b1;
						res_q.status     <= ST_INSERTED;
						res_q.position   <= 7'(lo_q);
						res_q.word_total <= 8'(count_q + 1'b1);
						state_q          <= S_OUT;
					end else begin
						byte_q <= byte_q + 1'b1;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						len_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_GATHER;
					end
				end
				default: state_q <= S_GATHER;
			endcase
		end
	end

	// Gather buffer: a byte is written on arrival, the rest kept at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LEN; i++) begin
				word_q[i] <= '0;
			end
		end else if (state_q == S_GATHER && in_valid && !overflow_now) begin
			word_q[len_q[LW-1:0]] <= ch;
		end else if (state_q == S_OUT && out_ready) begin
			for (int i = 0; i < MAX_LEN; i++) begin
				word_q[i] <= '0;
			end
		end
	end

endmodule

// ----- dv/suws_checker.sv -----
// ---------------------------------------------------------------------------
// suws_checker: predicts and checks results of the sorted word set
// Watches both channels. It folds each accepted byte into its own copy of the
// word being gathered and of the sorted table. At each word end it queues the
// expected status, position and word total. Each result is then compared
// with the oldest expected one.
// ---------------------------------------------------------------------------
module suws_checker import suws_pkg::*; #(
	parameter int unsigned CAPACITY = DefCapacity,
	parameter int unsigned MAX_LEN  = DefMaxLen
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_word_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_word_t out_data,
	output int        fail_count,
	output int        pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [MAX_LEN*8-1:0] row_t;

	row_t        table_rows[CAPACITY];
	int unsigned row_count;
	row_t        gather_row;
	int unsigned gather_len;
	logic        gather_over;
	out_word_t   expected_results[$];

	// Place the byte at index k of a row so that the first byte is the most significant.
	function automatic row_t put_byte(row_t r, int unsigned k, logic [7:0] b);
		r[(MAX_LEN-1-k)*8 +: 8] = b;
		return r;
	endfunction

	// Take in one byte; at a word end, search and insert, and queue the result.
	task automatic absorb_byte(in_word_t w);
		logic [7:0]  ch;
		int unsigned lo, hi, mid;
		bit          found;
		out_word_t   res;
		ch = w.char_code;
		if (ch >= 8'h41 && ch <= 8'h5A) ch = ch + 8'd32;
		if (gather_len < MAX_LEN) begin
			gather_row = put_byte(gather_row, gather_len, ch);
			gather_len++;
		end else begin
			gather_over = 1'b1;
		end
		if (!w.word_end) return;
		res.position = '0;
		if (gather_over) begin
			res.status = ST_TOO_LONG;
		end else if (row_count >= CAPACITY) begin
			res.status = ST_FULL;
		end else begin
			lo = 0;
			hi = row_count;
			found = 0;
			while (lo < hi) begin
				mid = (lo + hi) / 2;
				if (table_rows[mid] == gather_row) begin
					lo = mid;
					found = 1;
					break;
				end
				if (table_rows[mid] < gather_row) lo = mid + 1;
				else hi = mid;
			end
			if (found) begin
				res.status = ST_PRESENT;
			end else begin
				for (int unsigned r = row_count; r > lo; r--)
					table_rows[r] = table_rows[r-1];
				table_rows[lo] = gather_row;
				row_count++;
				res.status = ST_INSERTED;
			end
			res.position = lo[6:0];
		end
		res.word_total = row_count[7:0];
		expected_results.push_back(res);
		gather_row = '0;
		gather_len = 0;
		gather_over = 1'b0;
	endtask

	// Sample both channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			row_count = 0;
			gather_row = '0;
			gather_len = 0;
			gather_over = 1'b0;
			fail_count = 0;
			expected_results.delete();
		end else begin
			if (in_valid && in_ready) absorb_byte(in_data);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with nothing expected: %p", out_data);
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					if (out_data.status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, out_data.status);
						fail_count++;
					end
					if (out_data.position !== e.position) begin
						$error("position: expected %0d, got %0d", e.position,
							out_data.position);
						fail_count++;
					end
					if (out_data.word_total !== e.word_total) begin
						$error("word_total: expected %0d, got %0d", e.word_total,
							out_data.word_total);
						fail_count++;
					end
				end
			end
		end
		pending_count = expected_results.size();
	end

endmodule

// ----- dv/tb.sv -----
// ---------------------------------------------------------------------------
// tb: testbench top for the sorted word set
// Sends words byte by byte: first directed words, then, with random gaps and
// random result stalls, words drawn from a small vocabulary and fresh words
// so that repeats and over-long words occur, then enough words to fill the table.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import suws_pkg::*;

	localparam int unsigned CapacityN = DefCapacity;
	localparam int unsigned MaxLenN   = DefMaxLen;
	localparam longint CycleLimit     = 20000000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;
	int        fail_count, pending_count;
	longint    cycle_count = 0;
	int        bytes_sent = 0;
	bit        stalls_on = 1'b1;
	logic [7:0] vocab[16][];

	always #5 clk = ~clk;

	sorted_unique_word_set #(.CAPACITY(CapacityN), .MAX_LEN(MaxLenN)) dut (.*);

	suws_checker #(.CAPACITY(CapacityN), .MAX_LEN(MaxLenN)) checker_i (.*);

	// Give up on a run that is well past the slowest correct one.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("FAIL sorted_unique_word_set");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		if ($urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Result side: random stalls on out_ready.
	always @(negedge clk) begin
		if (!arst_n || !stalls_on) out_ready <= 1'b1;
		else out_ready <= (gap_len() == 0);
	end

	// Send one byte and wait for it to be taken; valid drops only for a gap.
	task automatic send_byte(logic [7:0] c, logic last);
		int n;
		n = stalls_on ? gap_len() : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_data.char_code <= c;
		in_data.word_end <= last;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_word(logic [7:0] w[]);
		foreach (w[i]) send_byte(w[i], i == w.size() - 1);
	endtask

	// A word of random bytes, some letters in either case.
	function automatic void random_word(ref logic [7:0] w[], input int n, input bit letters);
		w = new[n];
		foreach (w[i]) w[i] = letters ? 8'($urandom_range(0, 1) ? $urandom_range(65, 90)
			: $urandom_range(97, 122)) : 8'($urandom_range(0, 255));
	endfunction

	initial begin
		logic [7:0] w[];
		int pick;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		stalls_on = 1'b0;
		// Directed: extremes, case folding, zero bytes, repeats, length limits.
		send_word('{8'h00});
		send_word('{8'hFF});
		send_word('{8'h41, 8'h42});
		send_word('{8'h61, 8'h62});
		send_word('{8'h5A, 8'h40, 8'h5B, 8'h60, 8'h7B});
		send_word('{8'h61, 8'h00, 8'h62});
		send_word('{8'h61});
		random_word(w, MaxLenN, 1'b1);
		send_word(w);
		random_word(w, MaxLenN + 1, 1'b0);
		send_word(w);
		random_word(w, MaxLenN + 5, 1'b1);
		send_word(w);
		send_word('{8'hAA, 8'h55});
		send_word('{8'h55, 8'hAA});
		send_word('{8'hFF});
		stalls_on = 1'b1;
		// Random: a vocabulary of repeated words, fresh words and a few long ones.
		foreach (vocab[i]) random_word(vocab[i], $urandom_range(1, 4), 1'b1);
		while (bytes_sent < 1100) begin
			pick = $urandom_range(0, 19);
			if (pick < 8) send_word(vocab[$urandom_range(0, 15)]);
			else if (pick < 17) begin
				random_word(w, $urandom_range(1, 3), pick < 13);
				send_word(w);
			end else if (pick < 19) begin
				random_word(w, $urandom_range(MaxLenN - 1, MaxLenN + 2), pick == 17);
				send_word(w);
			end else begin
				random_word(w, 1, 1'b0);
				send_word(w);
			end
		end
		// Fill the table to capacity so that refusals are seen.
		stalls_on = 1'b0;
		for (int i = 0; i < CapacityN + 4; i++) begin
			random_word(w, 3, 1'b0);
			send_word(w);
		end
		send_word(vocab[0]);
		random_word(w, MaxLenN + 1, 1'b1);
		send_word(w);
		in_valid <= 1'b0;
		wait (pending_count == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0) $display("PASS sorted_unique_word_set");
		else $display("FAIL sorted_unique_word_set");
		$finish;
	end

endmodule

// ----- sorted_unique_word_set.f -----
rtl/core/suws_pkg.sv
rtl/core/suws_store.sv
rtl/core/sorted_unique_word_set.sv
dv/suws_checker.sv
dv/tb.sv
